// ===== rtl/tmif_pkg.sv =====
// Shared types and constants for the multi-line terminal interface.
package tmif_pkg;

   localparam int unsigned MAX_LINES_DEF = 16;
   localparam int unsigned LINE_W = 4;
   localparam int unsigned LINE_SPAN = 16;
   localparam int unsigned WORD_W = 18;
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned DEV_W = 6;
   localparam int unsigned PULSE_W = 6;
   localparam int unsigned COUNT_W = 5;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 6;

   localparam int unsigned PULSE_SKIP_BIT = 0;
   localparam int unsigned PULSE_CLEAR_BIT = 1;
   localparam int unsigned PULSE_LOAD_BIT = 2;

   localparam logic [COUNT_W-1:0] LINE_COUNT_RESET = 5'd1;

   typedef enum logic [1:0] {
      KIND_IOT = 2'd0,
      KIND_RX  = 2'd1,
      KIND_TX  = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_DEVICE    = 2'd0,
      CSR_LINE_COUNT     = 2'd1,
      CSR_SUBDEVICE_MODE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [DEV_W-1:0]   device_number;
      logic [PULSE_W-1:0] pulse;
      logic [WORD_W-1:0]  data_in;
      logic [LINE_W-1:0]  event_line;
      logic [CHAR_W-1:0]  rx_char;
      logic               rx_break;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] data_out;
      logic              skip;
      logic              input_interrupt;
      logic              output_interrupt;
      logic              tx_start;
      logic [LINE_W-1:0] tx_line;
      logic [CHAR_W-1:0] tx_char;
   } rsp_type;

   typedef struct packed {
      logic [DEV_W-1:0]   base_device;
      logic [COUNT_W-1:0] line_count;
      logic               subdevice_mode;
   } cfg_type;

   typedef struct packed {
      logic [LINE_W-1:0] line;
      logic              iot;
      logic              test_in;
      logic              test_out;
      logic              clr_in;
      logic              clr_out;
      logic              set_in;
      logic              set_out;
      logic              rd_rx;
      logic              wr_rx;
      logic              load;
      logic [CHAR_W-1:0] wr_char;
   } op_type;

endpackage

// ===== rtl/terminal_mux_iot_flags_unit.sv =====
// Top level of the multi-line terminal interface: beat registers, config and result build.
//
//   channel | direction | handshake          | beat
//   req     | in        | req_valid/req_stall | tmif_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall | tmif_pkg::rsp_type
//   csr     | in        | csr_we             | csr_index, csr_wdata
//
// One beat per cycle while rsp is not stalled; a beat passes through the input register and then the result register.
// The line state updates as a beat moves from the input register to the
// result register. Synchronous reset clears flags and buffers and sets config to its defaults.
// A stalled rsp holds the result and back-pressures req while the input register holds a beat.
module terminal_mux_iot_flags_unit #(
   parameter int unsigned MaxLines = tmif_pkg::MAX_LINES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tmif_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tmif_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [tmif_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tmif_pkg::CSR_DATA_W-1:0] csr_wdata
);

   tmif_pkg::cfg_type           cfg_ff;
   logic                        s1_valid_ff;
   tmif_pkg::req_type           s1_data_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   tmif_pkg::rsp_type           rsp_data_ff;
   tmif_pkg::rsp_type           rsp_data_in;
   logic                        advance;
   logic                        take;
   tmif_pkg::op_type            op;
   logic [tmif_pkg::CHAR_W-1:0] rx_rd;
   logic                        skip;
   logic                        in_irq;
   logic                        out_irq;

   tmif_decode #(.MaxLines(MaxLines)) u_decode (
      .item (s1_data_ff),
      .cfg  (cfg_ff),
      .op   (op)
   );

   tmif_lines #(.MaxLines(MaxLines)) u_lines (
      .clock   (clock),
      .reset   (reset),
      .commit  (advance),
      .op      (op),
      .rx_rd   (rx_rd),
      .skip    (skip),
      .in_irq  (in_irq),
      .out_irq (out_irq)
   );

   always_comb begin
      advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall = s1_valid_ff && !advance;
      take = req_valid && !req_stall;
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

      rsp_data_in = '0;
      if (op.iot) begin
         rsp_data_in.data_out = s1_data_ff.data_in |
                                tmif_pkg::WORD_W'(op.rd_rx ? rx_rd : '0);
         rsp_data_in.skip = skip;
      end
      if (op.load) begin
         rsp_data_in.tx_start = 1'b1;
         rsp_data_in.tx_line = op.line;
         rsp_data_in.tx_char = s1_data_ff.data_in[tmif_pkg::CHAR_W-1:0];
      end
      rsp_data_in.input_interrupt = in_irq;
      rsp_data_in.output_interrupt = out_irq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_device <= '0;
         cfg_ff.line_count <= tmif_pkg::LINE_COUNT_RESET;
         cfg_ff.subdevice_mode <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            tmif_pkg::CSR_BASE_DEVICE: begin
               cfg_ff.base_device <= csr_wdata;
            end
            tmif_pkg::CSR_LINE_COUNT: begin
               cfg_ff.line_count <= csr_wdata[tmif_pkg::COUNT_W-1:0];
            end
            tmif_pkg::CSR_SUBDEVICE_MODE: begin
               cfg_ff.subdevice_mode <= csr_wdata[0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= take || (s1_valid_ff && !advance);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ===== rtl/tmif_decode.sv =====
// Item decode: device offset, line select and per-line flag operations.
module tmif_decode #(
   parameter int unsigned MaxLines = tmif_pkg::MAX_LINES_DEF
) (
   input  tmif_pkg::req_type item,
   input  tmif_pkg::cfg_type cfg,
   output tmif_pkg::op_type  op
);

   logic [tmif_pkg::DEV_W-1:0]  offset;
   logic                        mine;
   logic [tmif_pkg::LINE_W-1:0] iot_line;
   logic [tmif_pkg::LINE_W-1:0] line;
   logic                        line_ok;
   logic                        iot_go;
   logic                        ev_go;
   logic                        in_side;

   always_comb begin
      offset = item.device_number - cfg.base_device;
      mine = (offset[tmif_pkg::DEV_W-1:3] == '0);
      in_side = offset[0];
      if (cfg.subdevice_mode) begin
         iot_line = {offset[2:1], item.pulse[5:4]};
      end else begin
         iot_line = {2'b00, offset[2:1]};
      end
      line = (item.kind == tmif_pkg::KIND_IOT) ? iot_line : item.event_line;
      line_ok = ({1'b0, line} < cfg.line_count) &&
                (32'(line) < MaxLines);
      iot_go = (item.kind == tmif_pkg::KIND_IOT) && mine && line_ok;
      ev_go = line_ok;

      op = '0;
      op.line = line;
      op.wr_char = item.rx_break ? '0 : item.rx_char;
      case (item.kind)
         tmif_pkg::KIND_IOT: begin
            op.iot = 1'b1;
            if (iot_go) begin
               if (in_side) begin
                  op.test_in = item.pulse[tmif_pkg::PULSE_SKIP_BIT];
                  op.clr_in = item.pulse[tmif_pkg::PULSE_CLEAR_BIT];
                  op.rd_rx = item.pulse[tmif_pkg::PULSE_CLEAR_BIT];
               end else begin
                  op.test_out = item.pulse[tmif_pkg::PULSE_SKIP_BIT];
                  op.clr_out = item.pulse[tmif_pkg::PULSE_CLEAR_BIT];
                  op.load = item.pulse[tmif_pkg::PULSE_LOAD_BIT];
               end
            end
         end
         tmif_pkg::KIND_RX: begin
            op.set_in = ev_go;
            op.wr_rx = ev_go;
         end
         tmif_pkg::KIND_TX: begin
            op.set_out = ev_go;
         end
         default: begin
            op.iot = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/tmif_lines.sv =====
// Per-line done flags and receive buffers, with skip test and interrupt summary.
module tmif_lines #(
   parameter int unsigned MaxLines = tmif_pkg::MAX_LINES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        commit,
   input  tmif_pkg::op_type            op,
   output logic [tmif_pkg::CHAR_W-1:0] rx_rd,
   output logic                        skip,
   output logic                        in_irq,
   output logic                        out_irq
);

   logic [tmif_pkg::LINE_SPAN-1:0] dec;
   logic [MaxLines-1:0]            sel;
   logic [MaxLines-1:0]            in_flags_ff;
   logic [MaxLines-1:0]            in_flags_in;
   logic [MaxLines-1:0]            out_flags_ff;
   logic [MaxLines-1:0]            out_flags_in;
   logic [tmif_pkg::CHAR_W-1:0]    rx_buf_ff [MaxLines];

   always_comb begin
      dec = tmif_pkg::LINE_SPAN'(1) << op.line;
      sel = dec[MaxLines-1:0];
      rx_rd = '0;
      for (int i = 0; i < MaxLines; i++) begin
         if (sel[i]) begin
            rx_rd = rx_rd | rx_buf_ff[i];
         end
      end
      skip = (op.test_in && ((in_flags_ff & sel) != '0)) ||
             (op.test_out && ((out_flags_ff & sel) != '0));
      in_flags_in = (in_flags_ff & ~(op.clr_in ? sel : '0)) | (op.set_in ? sel : '0);
      out_flags_in = (out_flags_ff & ~(op.clr_out ? sel : '0)) | (op.set_out ? sel : '0);
      in_irq = (in_flags_in != '0);
      out_irq = (out_flags_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flags_ff <= '0;
         out_flags_ff <= '0;
         for (int i = 0; i < MaxLines; i++) begin
            rx_buf_ff[i] <= '0;
         end
      end else if (commit) begin
         in_flags_ff <= in_flags_in;
         out_flags_ff <= out_flags_in;
         for (int i = 0; i < MaxLines; i++) begin
            if (op.wr_rx && sel[i]) begin
               rx_buf_ff[i] <= op.wr_char;
            end
         end
      end
   end

endmodule

// ===== verif/terminal_mux_iot_flags_unit_test.sv =====
// Self-checking testbench for the multi-line terminal interface: IOT decode, line flags and buffers.
`timescale 1ns / 1ps

module terminal_mux_iot_flags_unit_test;

   localparam int unsigned CLK_PERIOD = 10;
   localparam int unsigned RESET_CYCLES = 8;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned IDLE_PCT = 25;
   localparam int unsigned HOLD_CYCLES = 150;
   localparam int unsigned MAX_REPORTS = 40;
   localparam longint unsigned TIMEOUT_NS = 2_000_000;

   localparam logic [1:0] KIND_UNKNOWN = 2'd3;
   localparam logic [2:0] OP_SKIP = 3'(1 << tmif_pkg::PULSE_SKIP_BIT);
   localparam logic [2:0] OP_CLEAR = 3'(1 << tmif_pkg::PULSE_CLEAR_BIT);
   localparam logic [2:0] OP_LOAD = 3'(1 << tmif_pkg::PULSE_LOAD_BIT);
   localparam logic SIDE_OUT = 1'b0;
   localparam logic SIDE_IN = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tmif_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   tmif_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [tmif_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tmif_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // line model
   logic [5:0] cfg_base;
   logic [4:0] cfg_count;
   logic cfg_sub;
   logic [15:0] in_done_flags;
   logic [15:0] out_done_flags;
   logic [7:0] rx_buf [16];
   logic [7:0] tx_buf [16];

   tmif_pkg::rsp_type pending_results[$];
   int unsigned mismatch_count = 0;
   int unsigned beats_sent = 0;
   int unsigned send_idle_pct = IDLE_PCT;
   int unsigned recv_stall_pct = IDLE_PCT;
   int unsigned hold_request_count = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   terminal_mux_iot_flags_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic line_in_use(input logic [3:0] ln);
      return ({1'b0, ln} < cfg_count) && (int'(ln) < tmif_pkg::MAX_LINES_DEF);
   endfunction

   function automatic tmif_pkg::rsp_type compute_line_result(input tmif_pkg::req_type r);
      tmif_pkg::rsp_type o;
      logic [5:0] off;
      logic [3:0] ln;
      o = '0;
      case (r.kind)
         tmif_pkg::KIND_IOT: begin
            off = r.device_number - cfg_base;
            o.data_out = r.data_in;
            if (off < 6'd8) begin
               ln = {2'b00, off[2:1]};
               if (cfg_sub) ln = {off[2:1], r.pulse[5:4]};
               if (line_in_use(ln)) begin
                  if (off[0]) begin
                     if (r.pulse[tmif_pkg::PULSE_SKIP_BIT] && in_done_flags[ln])
                        o.skip = 1'b1;
                     if (r.pulse[tmif_pkg::PULSE_CLEAR_BIT]) begin
                        in_done_flags[ln] = 1'b0;
                        o.data_out = o.data_out | {10'b0, rx_buf[ln]};
                     end
                  end else begin
                     if (r.pulse[tmif_pkg::PULSE_SKIP_BIT] && out_done_flags[ln])
                        o.skip = 1'b1;
                     if (r.pulse[tmif_pkg::PULSE_CLEAR_BIT]) out_done_flags[ln] = 1'b0;
                     if (r.pulse[tmif_pkg::PULSE_LOAD_BIT]) begin
                        tx_buf[ln] = r.data_in[7:0];
                        o.tx_start = 1'b1;
                        o.tx_line = ln;
                        o.tx_char = r.data_in[7:0];
                     end
                  end
               end
            end
         end
         tmif_pkg::KIND_RX: begin
            if (line_in_use(r.event_line)) begin
               rx_buf[r.event_line] = r.rx_break ? 8'h00 : r.rx_char;
               in_done_flags[r.event_line] = 1'b1;
            end
         end
         tmif_pkg::KIND_TX: begin
            if (line_in_use(r.event_line)) out_done_flags[r.event_line] = 1'b1;
         end
         default: ;
      endcase
      o.input_interrupt = |in_done_flags;
      o.output_interrupt = |out_done_flags;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch %s: got %0h, wanted %0h at %0t", what, got, want, $time);
   endtask

   always @(posedge clock) begin : scoreboard
      tmif_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("beat with nothing pending", 64'(rsp_data), 64'(0));
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.data_out !== want.data_out)
                  report_mismatch("data_out", 64'(rsp_data.data_out), 64'(want.data_out));
               if (rsp_data.skip !== want.skip)
                  report_mismatch("skip", 64'(rsp_data.skip), 64'(want.skip));
               if (rsp_data.input_interrupt !== want.input_interrupt)
                  report_mismatch("input_interrupt", 64'(rsp_data.input_interrupt),
                                  64'(want.input_interrupt));
               if (rsp_data.output_interrupt !== want.output_interrupt)
                  report_mismatch("output_interrupt", 64'(rsp_data.output_interrupt),
                                  64'(want.output_interrupt));
               if (rsp_data.tx_start !== want.tx_start)
                  report_mismatch("tx_start", 64'(rsp_data.tx_start), 64'(want.tx_start));
               if (rsp_data.tx_line !== want.tx_line)
                  report_mismatch("tx_line", 64'(rsp_data.tx_line), 64'(want.tx_line));
               if (rsp_data.tx_char !== want.tx_char)
                  report_mismatch("tx_char", 64'(rsp_data.tx_char), 64'(want.tx_char));
            end
         end
         if (req_valid && !req_stall) pending_results.push_back(compute_line_result(req_data));
      end
   end

   // receiver: random stall, or a long hold when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_request_count) begin
         hold_seen <= hold_request_count;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   task automatic reset_line_model();
      cfg_base = '0;
      cfg_count = tmif_pkg::LINE_COUNT_RESET;
      cfg_sub = 1'b1;
      in_done_flags = '0;
      out_done_flags = '0;
      for (int i = 0; i < 16; i++) begin
         rx_buf[i] = '0;
         tx_buf[i] = '0;
      end
   endtask

   task automatic send_beat(input tmif_pkg::req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input tmif_pkg::csr_index_type idx,
                            input logic [tmif_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         tmif_pkg::CSR_BASE_DEVICE: cfg_base = val;
         tmif_pkg::CSR_LINE_COUNT: cfg_count = val[4:0];
         tmif_pkg::CSR_SUBDEVICE_MODE: cfg_sub = val[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [5:0] base, input logic [5:0] count,
                             input logic sub);
      wait_idle();
      write_csr(tmif_pkg::CSR_BASE_DEVICE, base);
      write_csr(tmif_pkg::CSR_LINE_COUNT, count);
      write_csr(tmif_pkg::CSR_SUBDEVICE_MODE, {5'b0, sub});
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic tmif_pkg::req_type noise_beat();
      tmif_pkg::req_type r;
      r.kind = 2'($urandom_range(0, 3));
      r.device_number = 6'($urandom_range(0, 63));
      r.pulse = 6'($urandom_range(0, 63));
      r.data_in = 18'($urandom_range(0, 262143));
      r.event_line = 4'($urandom_range(0, 15));
      r.rx_char = 8'($urandom_range(0, 255));
      r.rx_break = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic tmif_pkg::req_type iot_beat(input logic [5:0] dev,
                                                  input logic [5:0] pulse,
                                                  input logic [17:0] data);
      tmif_pkg::req_type r;
      r = noise_beat();
      r.kind = tmif_pkg::KIND_IOT;
      r.device_number = dev;
      r.pulse = pulse;
      r.data_in = data;
      return r;
   endfunction

   function automatic tmif_pkg::req_type rx_beat(input logic [3:0] ln, input logic [7:0] ch,
                                                 input logic brk);
      tmif_pkg::req_type r;
      r = noise_beat();
      r.kind = tmif_pkg::KIND_RX;
      r.event_line = ln;
      r.rx_char = ch;
      r.rx_break = brk;
      return r;
   endfunction

   function automatic tmif_pkg::req_type tx_beat(input logic [3:0] ln);
      tmif_pkg::req_type r;
      r = noise_beat();
      r.kind = tmif_pkg::KIND_TX;
      r.event_line = ln;
      return r;
   endfunction

   // IOT addressed to a line under the current decode mode
   function automatic tmif_pkg::req_type iot_line_beat(input logic [3:0] ln,
                                                       input logic side,
                                                       input logic [2:0] op);
      tmif_pkg::req_type r;
      logic [2:0] off;
      off = cfg_sub ? {ln[3:2], side} : {ln[1:0], side};
      r = iot_beat(cfg_base + {3'b000, off}, 6'($urandom_range(0, 63)),
                   18'($urandom_range(0, 262143)));
      r.pulse[2:0] = op;
      if (cfg_sub) r.pulse[5:4] = ln[1:0];
      return r;
   endfunction

   function automatic logic [3:0] pick_line(input logic iot_reach);
      int unsigned lim;
      lim = (cfg_count > 16) ? 16 : cfg_count;
      if (iot_reach && !cfg_sub && lim > 4) lim = 4;
      if (lim == 0 || $urandom_range(0, 9) == 0)
         return (iot_reach && !cfg_sub) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      return 4'($urandom_range(0, lim - 1));
   endfunction

   function automatic tmif_pkg::req_type random_beat();
      tmif_pkg::req_type r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      r = noise_beat();
      if (pick < 35) begin
         r = iot_line_beat(pick_line(1'b1), 1'($urandom_range(0, 1)),
                           3'($urandom_range(0, 7)));
      end else if (pick < 45) begin
         r.kind = tmif_pkg::KIND_IOT;
      end else if (pick < 65) begin
         r = rx_beat(pick_line(1'b0), 8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else if (pick < 85) begin
         r = tx_beat(pick_line(1'b0));
      end else if (pick < 93) begin
         r.kind = KIND_UNKNOWN;
      end
      return r;
   endfunction

   // receive, read back, load, complete, then test and clear the output side
   task automatic run_line_exchange();
      logic [3:0] ln;
      logic [2:0] op;
      ln = pick_line(1'b1);
      op = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : (OP_SKIP | OP_CLEAR);
      send_beat(rx_beat(ln, 8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0));
      send_beat(iot_line_beat(ln, SIDE_IN, op));
      send_beat(iot_line_beat(ln, SIDE_OUT, OP_LOAD));
      send_beat(tx_beat(ln));
      send_beat(iot_line_beat(ln, SIDE_OUT, op));
   endtask

   task automatic run_random_phase(input int unsigned beats);
      int unsigned start;
      start = beats_sent;
      while (beats_sent - start < beats) begin
         if ($urandom_range(0, 99) < 50) run_line_exchange();
         else send_beat(random_beat());
      end
   endtask

   task automatic test_reset_defaults();
      tmif_pkg::req_type r;
      send_beat(iot_beat(6'd0, {3'b000, OP_SKIP}, 18'h00000));
      send_beat(rx_beat(4'd0, 8'hFF, 1'b0));
      send_beat(iot_beat(6'd1, {3'b000, OP_SKIP | OP_CLEAR}, 18'h00000));
      send_beat(rx_beat(4'd0, 8'hAA, 1'b1));
      send_beat(iot_beat(6'd1, {3'b000, OP_CLEAR}, 18'h3FFFF));
      send_beat(tx_beat(4'd0));
      send_beat(iot_beat(6'd0, {3'b000, OP_SKIP | OP_CLEAR | OP_LOAD}, 18'h3FF5A));
      send_beat(rx_beat(4'd1, 8'h55, 1'b0));
      send_beat(iot_beat(6'd2, {3'b000, OP_SKIP | OP_CLEAR | OP_LOAD}, 18'h2A5A5));
      send_beat(iot_beat(6'd8, {3'b000, OP_SKIP | OP_CLEAR | OP_LOAD}, 18'h15A5A));
      send_beat(iot_beat(6'd1, {2'b11, 1'b1, OP_SKIP | OP_CLEAR}, 18'h3FFFF));
      r = noise_beat();
      r.kind = KIND_UNKNOWN;
      send_beat(r);
   endtask

   task automatic test_config_extremes();
      set_config(6'd63, 6'd16, 1'b1);
      send_beat(rx_beat(4'd15, 8'h81, 1'b0));
      send_beat(iot_beat(6'd6, {2'b11, 1'b0, OP_SKIP | OP_CLEAR}, 18'h00100));
      send_beat(tx_beat(4'd15));
      send_beat(iot_beat(6'd5, {2'b11, 1'b1, OP_SKIP | OP_CLEAR | OP_LOAD}, 18'h3FFFF));
      send_beat(iot_beat(6'd62, {3'b111, OP_SKIP | OP_CLEAR | OP_LOAD}, 18'h3FFFF));
      set_config(6'd0, 6'd0, 1'b1);
      send_beat(rx_beat(4'd0, 8'h7E, 1'b0));
      send_beat(tx_beat(4'd0));
      send_beat(iot_beat(6'd1, {3'b000, OP_SKIP | OP_CLEAR}, 18'h00000));
      set_config(6'd21, 6'd31, 1'b0);
      send_beat(rx_beat(4'd3, 8'hC3, 1'b0));
      send_beat(iot_beat(6'd28, {3'b110, OP_SKIP | OP_CLEAR}, 18'h20000));
      send_beat(rx_beat(4'd12, 8'h01, 1'b0));
      send_beat(iot_beat(6'd21, {3'b111, OP_SKIP | OP_CLEAR | OP_LOAD}, 18'h000FF));
   endtask

   task automatic test_random_traffic();
      logic [5:0] count;
      for (int phase = 0; phase < 4; phase++) begin
         case ($urandom_range(0, 3))
            0: count = 6'd1;
            1: count = 6'd16;
            default: count = 6'($urandom_range(1, 16));
         endcase
         set_config(6'($urandom_range(0, 63)), count, 1'($urandom_range(0, 1)));
         run_random_phase(75);
      end
      // full rate both ways
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      run_random_phase(60);
      send_idle_pct = IDLE_PCT;
      recv_stall_pct <= IDLE_PCT;
   endtask

   task automatic test_receiver_hold();
      send_idle_pct = 0;
      hold_request_count <= hold_request_count + 1;
      repeat (40) send_beat(random_beat());
      send_idle_pct = IDLE_PCT;
   endtask

   task automatic test_sender_pause();
      repeat (15) send_beat(random_beat());
      wait_idle();
      repeat (15) send_beat(random_beat());
   endtask

   initial begin
      reset_line_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_config_extremes();
      test_random_traffic();
      test_receiver_hold();
      test_sender_pause();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("PASS terminal_mux_iot_flags_unit");
      end else begin
         $display("FAIL terminal_mux_iot_flags_unit");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAIL terminal_mux_iot_flags_unit");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tmif_pkg.sv
rtl/tmif_decode.sv
rtl/tmif_lines.sv
rtl/terminal_mux_iot_flags_unit.sv
verif/terminal_mux_iot_flags_unit_test.sv
